### hdl/mrt_pkg.sv
`default_nettype none

package mrt_pkg;

   // Table geometry
   localparam int MAX_REGIONS   = 64;
   localparam int IDX_W         = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W         = $clog2(MAX_REGIONS + 1);
   localparam int ENTRY_COUNT_W = 7;
   localparam int ADDR_W        = 64;

   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [ENTRY_COUNT_W-1:0] count_out_type;
   typedef logic [ADDR_W-1:0]        addr_type;

   // Function codes
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_WRAP = 2'd2;

   // Region kinds that matter to the statistics
   localparam logic [3:0] KIND_USABLE       = 4'd0;
   localparam logic [3:0] KIND_ACPI_RECLAIM = 4'd2;
   localparam logic [3:0] KIND_BOOT_RECLAIM = 4'd5;
   localparam logic [3:0] KIND_EXEC         = 4'd6;

   // Entry write bus, shared by all cells
   typedef struct packed {
      addr_type base;
      addr_type rend;
      logic     usable;
   } wr_type;

   // Query token that walks the chain
   typedef struct packed {
      logic     valid;
      addr_type base;
      addr_type qend;
      logic     hit;
   } tok_type;

endpackage

`default_nettype wire

### hdl/mrt_if.sv
`default_nettype none

interface mrt_req_if;
   logic             valid;
   logic             ready;
   logic [1:0]       func;
   mrt_pkg::addr_type region_base;
   mrt_pkg::addr_type region_length;
   logic [3:0]       region_type;

   modport source (output valid, func, region_base, region_length, region_type,
                   input ready);
   modport sink   (input valid, func, region_base, region_length, region_type,
                   output ready);
endinterface

interface mrt_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic                   contained;
   mrt_pkg::addr_type      total_bytes;
   mrt_pkg::addr_type      usable_bytes;
   mrt_pkg::addr_type      executable_bytes;
   mrt_pkg::addr_type      reserved_bytes;
   mrt_pkg::addr_type      largest_length;
   mrt_pkg::addr_type      largest_base;
   logic                   largest_found;
   mrt_pkg::count_out_type entry_count;

   modport source (output valid, status, contained, total_bytes, usable_bytes,
                   executable_bytes, reserved_bytes, largest_length, largest_base,
                   largest_found, entry_count,
                   input ready);
   modport sink   (input valid, status, contained, total_bytes, usable_bytes,
                   executable_bytes, reserved_bytes, largest_length, largest_base,
                   largest_found, entry_count,
                   output ready);
endinterface

`default_nettype wire

### hdl/mrt_cell.sv
`default_nettype none

// One table entry plus one stage of the query chain.
module mrt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_sel,
   input  mrt_pkg::wr_type  wr,
   input  logic             held,
   input  mrt_pkg::tok_type up_tok,
   output mrt_pkg::tok_type down_tok
);

   mrt_pkg::addr_type ebase_ff;
   mrt_pkg::addr_type eend_ff;
   logic              usable_ff;
   mrt_pkg::tok_type  tok_ff;
   mrt_pkg::tok_type  tok_in;
   logic              match;

   assign match = held && usable_ff && (up_tok.base >= ebase_ff) && (up_tok.qend <= eend_ff);

   always_comb begin
      tok_in     = up_tok;
      tok_in.hit = up_tok.hit | match;
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         ebase_ff  <= wr.base;
         eend_ff   <= wr.rend;
         usable_ff <= wr.usable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.base <= tok_in.base;
      tok_ff.qend <= tok_in.qend;
      tok_ff.hit  <= tok_in.hit;
   end

   assign down_tok = tok_ff;

endmodule

`default_nettype wire

### hdl/memory_region_table.sv
`default_nettype none

// Channel | Dir | Handshake       | Payload
// req     | in  | valid/ready     | func, region_base, region_length, region_type
// rsp     | out | valid/ready     | status, contained, sums, largest region, entry_count
//
// One request at a time. Clear, append, unknown functions and a query whose end
// wraps pass execute and done; the result is loaded once the output register
// is free. A query scans in between; its token walks the cell chain, one cell per
// cycle. The next request is accepted in the cycle after the result is loaded.
// Reset (synchronous) empties the table and zeroes all statistics at once; no
// clearing pass. A stalled result stays in the output register; the next request
// is accepted meanwhile and its result waits until the register is free.
module memory_region_table (
   input  logic        clock,
   input  logic        reset,
   mrt_req_if.sink     req_chan,
   mrt_rsp_if.source   rsp_chan
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // Control state
   logic [1:0]       state_ff, state_in;
   mrt_pkg::cnt_type count_ff, count_in;

   // Latched request
   logic [1:0]        op_ff;
   mrt_pkg::addr_type base_ff;
   mrt_pkg::addr_type len_ff;
   logic [3:0]        kind_ff;

   // Statistics
   mrt_pkg::addr_type total_ff, total_in;
   mrt_pkg::addr_type usable_ff, usable_in;
   mrt_pkg::addr_type exec_ff, exec_in;
   mrt_pkg::addr_type resv_ff, resv_in;
   mrt_pkg::addr_type best_len_ff, best_len_in;
   mrt_pkg::addr_type best_base_ff, best_base_in;

   // Item outcome
   logic [1:0] status_ff, status_in;
   logic       hit_ff, hit_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             o_status_ff;
   logic                   o_hit_ff;
   mrt_pkg::addr_type      o_total_ff, o_usable_ff, o_exec_ff, o_resv_ff;
   mrt_pkg::addr_type      o_len_ff, o_base_ff;
   logic                   o_found_ff;
   mrt_pkg::count_out_type o_count_ff;

   logic              accept;
   logic              full;
   logic              do_append;
   logic [mrt_pkg::ADDR_W:0] qend_wide;
   logic              wrap;
   logic              out_free;
   logic              load_out;
   mrt_pkg::wr_type   wr;
   mrt_pkg::tok_type  tok [0:mrt_pkg::MAX_REGIONS];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == mrt_pkg::cnt_type'(mrt_pkg::MAX_REGIONS));
   assign do_append      = (state_ff == S_EXEC) && (op_ff == mrt_pkg::FUNC_APPEND) && !full;
   assign qend_wide      = {1'b0, base_ff} + {1'b0, len_ff};
   assign wrap           = qend_wide[mrt_pkg::ADDR_W];
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign load_out       = (state_ff == S_DONE) && out_free;

   // Entry write bus: stored end is base + length, wrapping
   assign wr.base   = base_ff;
   assign wr.rend   = base_ff + len_ff;
   assign wr.usable = (kind_ff == mrt_pkg::KIND_USABLE);

   // Inject the query token into the head of the chain
   always_comb begin
      tok[0].valid = (state_ff == S_EXEC) && (op_ff == mrt_pkg::FUNC_QUERY) && !wrap;
      tok[0].base  = base_ff;
      tok[0].qend  = qend_wide[mrt_pkg::ADDR_W-1:0];
      tok[0].hit   = 1'b0;
   end

   // Chain of entry cells; a cell is held while its index is below the count
   for (genvar i = 0; i < mrt_pkg::MAX_REGIONS; i++) begin : g_cell
      mrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_sel   (do_append && (count_ff == mrt_pkg::cnt_type'(i))),
         .wr       (wr),
         .held     (mrt_pkg::cnt_type'(i) < count_ff),
         .up_tok   (tok[i]),
         .down_tok (tok[i+1])
      );
   end

   // Sequencer and statistics
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      usable_in    = usable_ff;
      exec_in      = exec_ff;
      resv_in      = resv_ff;
      best_len_in  = best_len_ff;
      best_base_in = best_base_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = mrt_pkg::ST_OK;
            hit_in    = 1'b0;
            state_in  = S_DONE;
            case (op_ff)
               mrt_pkg::FUNC_CLEAR: begin
                  count_in     = '0;
                  total_in     = '0;
                  usable_in    = '0;
                  exec_in      = '0;
                  resv_in      = '0;
                  best_len_in  = '0;
                  best_base_in = '0;
               end
               mrt_pkg::FUNC_APPEND: begin
                  if (full) begin
                     status_in = mrt_pkg::ST_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                     total_in = total_ff + len_ff;
                     // Kinds above the last code fall into the reserved class anyway
                     if (kind_ff inside {mrt_pkg::KIND_USABLE, mrt_pkg::KIND_ACPI_RECLAIM,
                                         mrt_pkg::KIND_BOOT_RECLAIM}) begin
                        usable_in = usable_ff + len_ff;
                     end else if (kind_ff == mrt_pkg::KIND_EXEC) begin
                        exec_in = exec_ff + len_ff;
                     end else begin
                        resv_in = resv_ff + len_ff;
                     end
                     // Strictly longer replaces: first of equal lengths wins
                     if ((kind_ff == mrt_pkg::KIND_USABLE) && (len_ff > best_len_ff)) begin
                        best_len_in  = len_ff;
                        best_base_in = base_ff;
                     end
                  end
               end
               mrt_pkg::FUNC_QUERY: begin
                  if (wrap) begin
                     status_in = mrt_pkg::ST_WRAP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  // unknown function: change nothing
               end
            endcase
         end
         S_SCAN: begin
            // Wait for the token to leave the tail of the chain
            if (tok[mrt_pkg::MAX_REGIONS].valid) begin
               hit_in   = tok[mrt_pkg::MAX_REGIONS].hit;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         usable_ff    <= '0;
         exec_ff      <= '0;
         resv_ff      <= '0;
         best_len_ff  <= '0;
         best_base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         usable_ff    <= usable_in;
         exec_ff      <= exec_in;
         resv_ff      <= resv_in;
         best_len_ff  <= best_len_in;
         best_base_ff <= best_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_chan.func;
         base_ff <= req_chan.region_base;
         len_ff  <= req_chan.region_length;
         kind_ff <= req_chan.region_type;
      end
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         o_status_ff <= status_ff;
         o_hit_ff    <= hit_ff;
         o_total_ff  <= total_ff;
         o_usable_ff <= usable_ff;
         o_exec_ff   <= exec_ff;
         o_resv_ff   <= resv_ff;
         o_len_ff    <= best_len_ff;
         o_base_ff   <= (best_len_ff != '0) ? best_base_ff : '0;
         o_found_ff  <= (best_len_ff != '0);
         o_count_ff  <= mrt_pkg::count_out_type'(count_ff);
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = o_status_ff;
   assign rsp_chan.contained        = o_hit_ff;
   assign rsp_chan.total_bytes      = o_total_ff;
   assign rsp_chan.usable_bytes     = o_usable_ff;
   assign rsp_chan.executable_bytes = o_exec_ff;
   assign rsp_chan.reserved_bytes   = o_resv_ff;
   assign rsp_chan.largest_length   = o_len_ff;
   assign rsp_chan.largest_base     = o_base_ff;
   assign rsp_chan.largest_found    = o_found_ff;
   assign rsp_chan.entry_count      = o_count_ff;

   // A token reaches the tail only while the sequencer waits for it
   a_tok_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[mrt_pkg::MAX_REGIONS].valid |-> (state_ff == S_SCAN))
      else $error("query token left chain outside scan");

   // The count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mrt_pkg::cnt_type'(mrt_pkg::MAX_REGIONS))
      else $error("entry count beyond table size");

   // An accepted request is executed in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request not executed");

   // A result is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(o_total_ff)))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

### tb/region_table_checker.sv
`default_nettype none

module region_table_checker
   import mrt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mrt_req_if   req_mon,
   mrt_rsp_if   rsp_mon,
   output int   failures,
   output int   results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] KIND_RESERVED = 4'd1;
   localparam logic [3:0] KIND_LAST     = 4'd8;
   localparam int         PRINT_CAP     = 50;

   typedef struct packed {
      logic [1:0]    status;
      logic          contained;
      addr_type      total;
      addr_type      usable;
      addr_type      exec;
      addr_type      reserved;
      addr_type      big_len;
      addr_type      big_base;
      logic          big_found;
      count_out_type count;
   } region_result_t;

   addr_type   tbl_base [MAX_REGIONS];
   addr_type   tbl_len  [MAX_REGIONS];
   logic [3:0] tbl_kind [MAX_REGIONS];
   int         held;
   addr_type   acc_total, acc_usable, acc_exec, acc_reserved;
   addr_type   top_len, top_base;

   region_result_t owed_results[$];
   int miss_count = 0;
   int owed_now   = 0;

   assign failures     = miss_count;
   assign results_owed = owed_now;

   function automatic void empty_table();
      held         = 0;
      acc_total    = '0;
      acc_usable   = '0;
      acc_exec     = '0;
      acc_reserved = '0;
      top_len      = '0;
      top_base     = '0;
   endfunction

   // Apply one request to the shadow table and return the statistics after it.
   function automatic region_result_t predict_region_op(input logic [1:0] f,
                                                        input addr_type b,
                                                        input addr_type l,
                                                        input logic [3:0] t);
      region_result_t r;
      logic [3:0]     k;
      logic [64:0]    qend;
      logic           hit;
      r   = '0;
      hit = 1'b0;
      case (f)
         FUNC_CLEAR: empty_table();
         FUNC_APPEND: begin
            k = (t > KIND_LAST) ? KIND_RESERVED : t;
            if (held >= MAX_REGIONS) begin
               r.status = ST_FULL;
            end else begin
               tbl_base[held] = b;
               tbl_len[held]  = l;
               tbl_kind[held] = k;
               held++;
               acc_total += l;
               if (k == KIND_USABLE || k == KIND_ACPI_RECLAIM || k == KIND_BOOT_RECLAIM) begin
                  acc_usable += l;
                  // strictly longer only: the first of equal lengths stays
                  if (k == KIND_USABLE && l > top_len) begin
                     top_len  = l;
                     top_base = b;
                  end
               end else if (k == KIND_EXEC) begin
                  acc_exec += l;
               end else begin
                  acc_reserved += l;
               end
            end
         end
         FUNC_QUERY: begin
            qend = {1'b0, b} + {1'b0, l};
            if (qend[64]) begin
               r.status = ST_WRAP;
            end else begin
               for (int i = 0; i < held; i++) begin
                  if (!hit && tbl_kind[i] == KIND_USABLE && b >= tbl_base[i] &&
                      qend[63:0] <= addr_type'(tbl_base[i] + tbl_len[i]))
                     hit = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.contained = hit;
      r.total     = acc_total;
      r.usable    = acc_usable;
      r.exec      = acc_exec;
      r.reserved  = acc_reserved;
      r.big_len   = top_len;
      r.big_base  = (top_len != 0) ? top_base : '0;
      r.big_found = (top_len != 0);
      r.count     = count_out_type'(held);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (miss_count < PRINT_CAP)
         $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
      miss_count++;
   endtask

   task automatic check_response();
      region_result_t want;
      if (owed_results.size() == 0) begin
         report_mismatch("response with no request pending", '0, '0);
         return;
      end
      want = owed_results.pop_front();
      if (rsp_mon.status !== want.status)
         report_mismatch("status", rsp_mon.status, want.status);
      if (rsp_mon.contained !== want.contained)
         report_mismatch("contained", rsp_mon.contained, want.contained);
      if (rsp_mon.total_bytes !== want.total)
         report_mismatch("total_bytes", rsp_mon.total_bytes, want.total);
      if (rsp_mon.usable_bytes !== want.usable)
         report_mismatch("usable_bytes", rsp_mon.usable_bytes, want.usable);
      if (rsp_mon.executable_bytes !== want.exec)
         report_mismatch("executable_bytes", rsp_mon.executable_bytes, want.exec);
      if (rsp_mon.reserved_bytes !== want.reserved)
         report_mismatch("reserved_bytes", rsp_mon.reserved_bytes, want.reserved);
      if (rsp_mon.largest_length !== want.big_len)
         report_mismatch("largest_length", rsp_mon.largest_length, want.big_len);
      if (rsp_mon.largest_base !== want.big_base)
         report_mismatch("largest_base", rsp_mon.largest_base, want.big_base);
      if (rsp_mon.largest_found !== want.big_found)
         report_mismatch("largest_found", rsp_mon.largest_found, want.big_found);
      if (rsp_mon.entry_count !== want.count)
         report_mismatch("entry_count", rsp_mon.entry_count, want.count);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         empty_table();
         owed_results.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            owed_results.push_back(predict_region_op(req_mon.func, req_mon.region_base,
                                                     req_mon.region_length,
                                                     req_mon.region_type));
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1)
            check_response();
      end
      owed_now = owed_results.size();
   end

endmodule

`default_nettype wire

### tb/memory_region_table_test.sv
`default_nettype none

module memory_region_table_test;
   import mrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // func code 3 is not decoded by the block; it must change nothing
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
   localparam int         TOTAL_ITEMS  = 1450;
   localparam int         PHASE_ITEMS  = 480;
   localparam int         LONG_HOLD    = 400;

   logic clock;
   logic reset;
   int   failures;
   int   results_owed;

   // idle odds in percent, changed per phase by the stimulus
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   long_hold_request;
   int   sent_items;
   int   phase;

   // region list as the stimulus sees it, used to aim queries at stored regions
   addr_type   map_base[$];
   addr_type   map_len[$];
   logic [3:0] map_kind[$];

   mrt_req_if req_bus();
   mrt_rsp_if rsp_bus();

   memory_region_table DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   region_table_checker table_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .failures     (failures),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run of all requests.
   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: drive ready at the falling edge. A long hold-off, once asked
   // for, is counted down here while the sender keeps offering requests.
   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            hold_left         = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic addr_type rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one request: idle at random first, then hold valid until accepted.
   // Valid stays high after acceptance; the next call or a drain decides it at
   // the next falling edge, so it is assigned once per step.
   task automatic issue_request(input logic [1:0] f, input addr_type b,
                                input addr_type l, input logic [3:0] t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.func          <= f;
      req_bus.region_base   <= b;
      req_bus.region_length <= l;
      req_bus.region_type   <= t;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent_items++;
      // track the table for aiming later queries
      if (f == FUNC_CLEAR) begin
         map_base.delete();
         map_len.delete();
         map_kind.delete();
      end else if (f == FUNC_APPEND && map_base.size() < MAX_REGIONS) begin
         map_base.push_back(b);
         map_len.push_back(l);
         map_kind.push_back(t);
      end
   endtask

   // Drop valid and hold the sender until every pending result has come.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   // Append a region: mostly usable, lengths biased to small, with zero
   // lengths and repeats of the last length to exercise ties.
   task automatic issue_append();
      addr_type   b;
      addr_type   l;
      logic [3:0] t;
      b = ($urandom_range(1) == 0) ? rand64() : addr_type'($urandom_range(0, 1 << 24));
      case ($urandom_range(7))
         0: l = '0;
         1: l = rand64();
         2: l = (map_len.size() != 0) ? map_len[$] : addr_type'($urandom_range(1, 4096));
         default: l = addr_type'($urandom_range(1, 1 << 20));
      endcase
      t = ($urandom_range(9) < 6) ? KIND_USABLE : 4'($urandom_range(15));
      issue_request(FUNC_APPEND, b, l, t);
   endtask

   // Query aimed at a stored region: inside, exact, off by one on either side,
   // empty ranges at the edges, or a range whose end wraps.
   task automatic issue_query();
      int       k;
      addr_type b;
      addr_type l;
      addr_type off;
      if (map_base.size() == 0 || $urandom_range(9) == 0) begin
         issue_request(FUNC_QUERY, rand64(), ($urandom_range(1) == 0) ? rand64() :
                       addr_type'($urandom_range(0, 1 << 16)), 4'($urandom_range(15)));
         return;
      end
      k = $urandom_range(map_base.size() - 1);
      b = map_base[k];
      l = map_len[k];
      case ($urandom_range(6))
         0: ;
         1: begin
            off = (l == 0) ? '0 : rand64() % l;
            b   = b + off;
            l   = (l - off == 0) ? '0 : rand64() % (l - off);
         end
         2: l = l + 1;
         3: b = b - 1;
         4: begin
            b = b + l;
            l = '0;
         end
         5: l = '0;
         default: l = ~b + addr_type'($urandom_range(1, 4));
      endcase
      issue_request(FUNC_QUERY, b, l, 4'($urandom_range(15)));
   endtask

   // One episode: usually clear, build a table, then probe it. A few episodes
   // overfill the table; some skip the clear; some are plain noise.
   task automatic run_episode();
      int n;
      if ($urandom_range(9) == 0) begin
         repeat (10)
            issue_request(2'($urandom_range(3)), rand64(), rand64(), 4'($urandom_range(15)));
         return;
      end
      if ($urandom_range(4) != 0)
         issue_request(FUNC_CLEAR, rand64(), rand64(), 4'($urandom_range(15)));
      n = ($urandom_range(14) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 16);
      repeat (n) issue_append();
      repeat ($urandom_range(3, 12)) issue_query();
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_CLEAR;
      req_bus.region_base   = '0;
      req_bus.region_length = '0;
      req_bus.region_type   = KIND_USABLE;
      send_idle_pct         = 25;
      recv_idle_pct         = 78;
      long_hold_request     = 1'b0;
      sent_items            = 0;
      phase                 = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, unknown function, ties, zero length, every type.
      issue_request(FUNC_QUERY, '0, '0, KIND_USABLE);
      issue_request(FUNC_UNKNOWN, rand64(), rand64(), 4'hF);
      issue_request(FUNC_APPEND, 64'h1000, 64'h1000, KIND_USABLE);
      issue_request(FUNC_APPEND, 64'h8000, 64'h1000, KIND_USABLE);
      issue_request(FUNC_APPEND, 64'h20000, '0, KIND_USABLE);
      for (int t = 1; t <= 9; t++)
         issue_request(FUNC_APPEND, 64'h100000 * t, 64'h10 * t, 4'(t));
      issue_request(FUNC_APPEND, 64'h200000, 64'h77, 4'hF);
      // probe inside, empty range at the end, one past the end, wrap, full span
      issue_request(FUNC_QUERY, 64'h1800, 64'h100, KIND_USABLE);
      issue_request(FUNC_QUERY, 64'h2000, '0, KIND_USABLE);
      issue_request(FUNC_QUERY, 64'h1000, 64'h1001, KIND_USABLE);
      issue_request(FUNC_QUERY, '1, 64'h1, KIND_USABLE);
      issue_request(FUNC_QUERY, '0, '1, KIND_USABLE);
      // extreme lengths wrap the sums; a region end that wraps
      issue_request(FUNC_APPEND, '1, '1, KIND_USABLE);
      issue_request(FUNC_APPEND, '0, '1, KIND_USABLE);
      issue_request(FUNC_QUERY, 64'h5, 64'hA, KIND_USABLE);
      issue_request(FUNC_CLEAR, '1, '1, 4'hF);
      issue_request(FUNC_QUERY, 64'h1800, 64'h100, KIND_USABLE);

      // Random: swap the idle odds per phase, pause the sender at each switch,
      // and hold the result side off for a long stretch at the switch too.
      while (sent_items < TOTAL_ITEMS) begin
         if (phase == 0 && sent_items >= PHASE_ITEMS) begin
            drain_results();
            send_idle_pct     = 78;
            recv_idle_pct     = 25;
            long_hold_request = 1'b1;
            phase             = 1;
         end else if (phase == 1 && sent_items >= 2 * PHASE_ITEMS) begin
            drain_results();
            send_idle_pct     = 0;
            recv_idle_pct     = 0;
            long_hold_request = 1'b1;
            phase             = 2;
         end
         run_episode();
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
